### sv/ocws_pkg.sv
// ----------------------------------------------------------------------------
// ocws_pkg
// Types and constants shared by the offset corrected window statistics block
// and its port checker.
// ----------------------------------------------------------------------------
package ocws_pkg;

   // field widths
   localparam int LINE_BITS     = 2;
   localparam int SAMPLE_BITS   = 16;
   localparam int SHIFT_BITS    = 14;
   localparam int CORR_BITS     = 17;
   localparam int LEN_BITS      = 16;
   localparam int SUM_BITS      = 32;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // block constants
   localparam int LINES      = 4;
   localparam int MAX_POINTS = 32768;
   localparam int SHIFT_BIAS = 0;
   localparam logic [LEN_BITS-1:0] LEN_RESET = 16'd1024;

   // the window sum magnitude stays within 2^30, so 31 quotient bits
   localparam int DIV_STEPS    = 31;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_SHIFT_A       = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHIFT_B       = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHIFT_C       = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHIFT_D       = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_STATS_ENABLE  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_WINDOW_LENGTH = 3'd5;

   // per line accumulator entry
   typedef struct packed {
      logic        [LEN_BITS-1:0]    cnt;
      logic signed [SAMPLE_BITS-1:0] lo;
      logic signed [SAMPLE_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0]    sum;
   } stat_entry_type;

   localparam stat_entry_type ENTRY_CLEAR = '{
      cnt: '0,
      lo:  16'sh7FFF,
      hi:  16'sh8000,
      sum: '0
   };

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_DONE
   } ocws_state_type;

endpackage

### sv/offset_corrected_window_stats.sv
// Sequence: the sample word is taken with the memory read, the entry is then
// updated read-modify-write, and the result is loaded into the output register;
// a window end with statistics on runs the 31-step divider before the load. A
// new sample is taken only after the result load, which waits on a result stall.
// Reset: registers return to their defaults, all line entries read as cleared,
// no result pending.
// ----------------------------------------------------------------------------
// offset_corrected_window_stats
// Per line zero shift correction with windowed min, max, average and integral,
// accumulators held in a small synchronous memory updated read-modify-write.
// ----------------------------------------------------------------------------
module offset_corrected_window_stats (
   input  logic                                      clock,
   input  logic                                      reset,
   // sample channel
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic        [ocws_pkg::LINE_BITS-1:0]     req_line,
   input  logic signed [ocws_pkg::SAMPLE_BITS-1:0]   req_raw_sample,
   // result channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic        [ocws_pkg::LINE_BITS-1:0]     rsp_line_out,
   output logic signed [ocws_pkg::CORR_BITS-1:0]     rsp_corrected_sample,
   output logic                                      rsp_window_end,
   output logic signed [ocws_pkg::CORR_BITS-1:0]     rsp_min_value,
   output logic signed [ocws_pkg::CORR_BITS-1:0]     rsp_max_value,
   output logic signed [ocws_pkg::CORR_BITS-1:0]     rsp_avg_value,
   output logic signed [ocws_pkg::SUM_BITS-1:0]      rsp_integral_value,
   // register write channel
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic        [ocws_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic        [ocws_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int NLINES = ocws_pkg::LINES;

   // configuration registers
   logic signed [ocws_pkg::SHIFT_BITS-1:0] shift_ff [NLINES];
   logic                                   stats_enable_ff;
   logic        [ocws_pkg::LEN_BITS-1:0]   window_length_ff;

   // sequencer
   ocws_pkg::ocws_state_type state_ff, state_in;
   logic accept;
   logic mem_we;
   logic out_free;
   logic out_load;
   logic div_last;

   // accumulator memory and its read port
   ocws_pkg::stat_entry_type stat_mem_ff [NLINES];
   logic [NLINES-1:0]        line_valid_ff;
   ocws_pkg::stat_entry_type stat_rd_ff;
   logic                     rd_valid_ff;

   // captured sample
   logic        [ocws_pkg::LINE_BITS-1:0]   hold_line_ff;
   logic signed [ocws_pkg::SAMPLE_BITS-1:0] hold_raw_ff;

   // results of the update step
   logic signed [ocws_pkg::CORR_BITS-1:0]  hold_corr_ff;
   logic                                   hold_end_ff;
   logic                                   hold_stats_ff;
   logic signed [ocws_pkg::CORR_BITS-1:0]  hold_min_ff;
   logic signed [ocws_pkg::CORR_BITS-1:0]  hold_max_ff;
   logic signed [ocws_pkg::SUM_BITS-1:0]   hold_sum_ff;
   logic signed [ocws_pkg::SUM_BITS-1:0]   hold_prod_ff;
   logic signed [ocws_pkg::SHIFT_BITS-1:0] hold_shift_ff;

   // divider
   logic [ocws_pkg::LEN_BITS-1:0]     div_rem_ff;
   logic [ocws_pkg::DIV_STEPS-1:0]    div_quo_ff;
   logic [ocws_pkg::LEN_BITS-1:0]     divisor_ff;
   logic [ocws_pkg::DIV_CNT_BITS-1:0] div_cnt_ff;
   logic                              div_neg_ff;

   // output register
   logic                                   rsp_valid_ff;
   logic        [ocws_pkg::LINE_BITS-1:0]  rsp_line_ff;
   logic signed [ocws_pkg::CORR_BITS-1:0]  rsp_corr_ff;
   logic                                   rsp_end_ff;
   logic signed [ocws_pkg::CORR_BITS-1:0]  rsp_min_ff;
   logic signed [ocws_pkg::CORR_BITS-1:0]  rsp_max_ff;
   logic signed [ocws_pkg::CORR_BITS-1:0]  rsp_avg_ff;
   logic signed [ocws_pkg::SUM_BITS-1:0]   rsp_int_ff;

   // update step signals
   ocws_pkg::stat_entry_type cur_entry;
   ocws_pkg::stat_entry_type new_entry;
   ocws_pkg::stat_entry_type wr_entry;
   logic signed [ocws_pkg::SHIFT_BITS-1:0] line_shift;
   logic        [ocws_pkg::LEN_BITS-1:0]   len_eff;
   logic        [ocws_pkg::LEN_BITS-1:0]   new_cnt;
   logic                                   win_end;
   logic signed [ocws_pkg::SUM_BITS-1:0]   new_sum;
   logic signed [ocws_pkg::SUM_BITS-1:0]   sum_mag;
   logic signed [30:0]                     shift_len_prod;

   // divider step signals
   logic [ocws_pkg::LEN_BITS:0]   rem_shift;
   logic                          quo_bit;
   logic [ocws_pkg::LEN_BITS-1:0] rem_next;

   // result step signals
   logic signed [ocws_pkg::SUM_BITS-1:0] quo_signed;
   logic signed [ocws_pkg::SUM_BITS-1:0] avg_full;
   logic signed [ocws_pkg::SUM_BITS-1:0] int_full;

   assign csr_ready = 1'b1;

   // register writes, indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NLINES; i++) begin
            shift_ff[i] <= '0;
         end
         stats_enable_ff  <= 1'b0;
         window_length_ff <= ocws_pkg::LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ocws_pkg::REG_SHIFT_A: begin
               shift_ff[0] <= $signed(csr_wdata[ocws_pkg::SHIFT_BITS-1:0]);
            end
            ocws_pkg::REG_SHIFT_B: begin
               shift_ff[1] <= $signed(csr_wdata[ocws_pkg::SHIFT_BITS-1:0]);
            end
            ocws_pkg::REG_SHIFT_C: begin
               shift_ff[2] <= $signed(csr_wdata[ocws_pkg::SHIFT_BITS-1:0]);
            end
            ocws_pkg::REG_SHIFT_D: begin
               shift_ff[3] <= $signed(csr_wdata[ocws_pkg::SHIFT_BITS-1:0]);
            end
            ocws_pkg::REG_STATS_ENABLE: begin
               stats_enable_ff <= csr_wdata[0];
            end
            ocws_pkg::REG_WINDOW_LENGTH: begin
               window_length_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // effective window length, clamped to one and to the point limit
   always_comb begin
      if (window_length_ff == '0) begin
         len_eff = ocws_pkg::LEN_BITS'(1);
      end else if (32'(window_length_ff) > ocws_pkg::MAX_POINTS) begin
         len_eff = ocws_pkg::LEN_BITS'(ocws_pkg::MAX_POINTS);
      end else begin
         len_eff = window_length_ff;
      end
   end

   // accumulator update for the captured sample
   always_comb begin
      line_shift = shift_ff[hold_line_ff] + ocws_pkg::SHIFT_BITS'(ocws_pkg::SHIFT_BIAS);
      cur_entry  = rd_valid_ff ? stat_rd_ff : ocws_pkg::ENTRY_CLEAR;
      new_sum    = cur_entry.sum + ocws_pkg::SUM_BITS'(hold_raw_ff);
      new_cnt    = cur_entry.cnt + ocws_pkg::LEN_BITS'(1);
      win_end    = new_cnt >= len_eff;

      new_entry.cnt = new_cnt;
      new_entry.sum = new_sum;
      if (cur_entry.cnt == '0) begin
         new_entry.lo = hold_raw_ff;
         new_entry.hi = hold_raw_ff;
      end else begin
         new_entry.lo = (hold_raw_ff < cur_entry.lo) ? hold_raw_ff : cur_entry.lo;
         new_entry.hi = (hold_raw_ff > cur_entry.hi) ? hold_raw_ff : cur_entry.hi;
      end
      wr_entry = win_end ? ocws_pkg::ENTRY_CLEAR : new_entry;

      sum_mag        = (new_sum < 0) ? -new_sum : new_sum;
      shift_len_prod = line_shift * $signed({1'b0, len_eff});
   end

   // restoring divider step
   always_comb begin
      rem_shift = {div_rem_ff, div_quo_ff[ocws_pkg::DIV_STEPS-1]};
      quo_bit   = rem_shift >= {1'b0, divisor_ff};
      rem_next  = quo_bit ? ocws_pkg::LEN_BITS'(rem_shift - {1'b0, divisor_ff})
                          : ocws_pkg::LEN_BITS'(rem_shift);
      div_last  = div_cnt_ff == ocws_pkg::DIV_CNT_BITS'(ocws_pkg::DIV_STEPS - 1);
   end

   // average and integral from the divider and the held product
   always_comb begin
      quo_signed = ocws_pkg::SUM_BITS'({1'b0, div_quo_ff});
      if (div_neg_ff) begin
         quo_signed = -quo_signed;
      end
      avg_full = quo_signed - ocws_pkg::SUM_BITS'(hold_shift_ff);
      int_full = hold_sum_ff - hold_prod_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ocws_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ocws_pkg::ST_READ;
            end
         end
         ocws_pkg::ST_READ: begin
            if (win_end && stats_enable_ff) begin
               state_in = ocws_pkg::ST_DIV;
            end else begin
               state_in = ocws_pkg::ST_DONE;
            end
         end
         ocws_pkg::ST_DIV: begin
            if (div_last) begin
               state_in = ocws_pkg::ST_DONE;
            end
         end
         ocws_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ocws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ocws_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      out_load  = 1'b0;
      out_free  = !rsp_valid_ff || !rsp_stall;
      case (state_ff)
         ocws_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         ocws_pkg::ST_READ: begin
            mem_we = 1'b1;
         end
         ocws_pkg::ST_DIV: begin
         end
         ocws_pkg::ST_DONE: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
      accept = req_valid && !req_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ocws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // accumulator memory, registered read at accept, write back in the next cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stat_mem_ff[hold_line_ff] <= wr_entry;
      end
      if (accept) begin
         stat_rd_ff <= stat_mem_ff[req_line];
      end
   end

   // entry valid bits, an entry not yet written reads as cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            line_valid_ff[hold_line_ff] <= 1'b1;
         end
         if (accept) begin
            rd_valid_ff <= line_valid_ff[req_line];
         end
      end
   end

   // sample capture
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_line_ff <= req_line;
         hold_raw_ff  <= req_raw_sample;
      end
   end

   // update results and divider load
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hold_corr_ff  <= ocws_pkg::CORR_BITS'(hold_raw_ff) -
                          ocws_pkg::CORR_BITS'(line_shift);
         hold_min_ff   <= ocws_pkg::CORR_BITS'(new_entry.lo) -
                          ocws_pkg::CORR_BITS'(line_shift);
         hold_max_ff   <= ocws_pkg::CORR_BITS'(new_entry.hi) -
                          ocws_pkg::CORR_BITS'(line_shift);
         hold_end_ff   <= win_end;
         hold_stats_ff <= win_end && stats_enable_ff;
         hold_sum_ff   <= new_sum;
         hold_prod_ff  <= ocws_pkg::SUM_BITS'(shift_len_prod);
         hold_shift_ff <= line_shift;
         div_rem_ff    <= '0;
         div_quo_ff    <= sum_mag[ocws_pkg::DIV_STEPS-1:0];
         div_neg_ff    <= new_sum < 0;
         divisor_ff    <= len_eff;
         div_cnt_ff    <= '0;
      end else if (state_ff == ocws_pkg::ST_DIV) begin
         div_rem_ff <= rem_next;
         div_quo_ff <= {div_quo_ff[ocws_pkg::DIV_STEPS-2:0], quo_bit};
         div_cnt_ff <= div_cnt_ff + ocws_pkg::DIV_CNT_BITS'(1);
      end
   end

   // output register, statistics zero unless a window closes with stats on
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_line_ff <= hold_line_ff;
         rsp_corr_ff <= hold_corr_ff;
         rsp_end_ff  <= hold_end_ff;
         rsp_min_ff  <= hold_stats_ff ? hold_min_ff : '0;
         rsp_max_ff  <= hold_stats_ff ? hold_max_ff : '0;
         rsp_avg_ff  <= hold_stats_ff ? avg_full[ocws_pkg::CORR_BITS-1:0] : '0;
         rsp_int_ff  <= hold_stats_ff ? int_full : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_line_out         = rsp_line_ff;
   assign rsp_corrected_sample = rsp_corr_ff;
   assign rsp_window_end       = rsp_end_ff;
   assign rsp_min_value        = rsp_min_ff;
   assign rsp_max_value        = rsp_max_ff;
   assign rsp_avg_value        = rsp_avg_ff;
   assign rsp_integral_value   = rsp_int_ff;

endmodule

### sv/ocws_checker.sv
// ----------------------------------------------------------------------------
// ocws_checker
// Port level checks for the offset corrected window statistics block.
// ----------------------------------------------------------------------------
module ocws_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      req_valid,
   input logic                                      req_stall,
   input logic                                      rsp_valid,
   input logic                                      rsp_stall,
   input logic        [ocws_pkg::LINE_BITS-1:0]     rsp_line_out,
   input logic signed [ocws_pkg::CORR_BITS-1:0]     rsp_corrected_sample,
   input logic                                      rsp_window_end,
   input logic signed [ocws_pkg::CORR_BITS-1:0]     rsp_min_value,
   input logic signed [ocws_pkg::CORR_BITS-1:0]     rsp_max_value,
   input logic signed [ocws_pkg::CORR_BITS-1:0]     rsp_avg_value,
   input logic signed [ocws_pkg::SUM_BITS-1:0]      rsp_integral_value
);

   // no result word right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_out) &&
         $stable(rsp_corrected_sample) && $stable(rsp_window_end) &&
         $stable(rsp_min_value) && $stable(rsp_max_value) &&
         $stable(rsp_avg_value) && $stable(rsp_integral_value))
      else $error("stalled result word changed");

   // one sample in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sample word taken while another is in work");

   // statistics only on a window end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_window_end |-> rsp_min_value == '0 &&
         rsp_max_value == '0 && rsp_avg_value == '0 && rsp_integral_value == '0)
      else $error("statistics outside a window end");

   // window minimum never above maximum
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_window_end |-> rsp_min_value <= rsp_max_value)
      else $error("window minimum above maximum");

endmodule

bind offset_corrected_window_stats ocws_checker u_ocws_checker (.*);
